FILE: rtl/core/trm_pkg.sv
// ----------------------------------------------------------------------------
// trm_pkg
// Shared widths, register indexes and the command/status bundles that join
// the resampler controller to its datapath.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int SMP_W    = 32;   // sample / gain / result width
  localparam int CNT_W    = 17;   // point counts and indexes
  localparam int PROD_W   = 64;   // |gain| * |operand| magnitude
  localparam int SCALE_SH = 17;   // operand carries one extra bit, so Q16.16 -> 17
  localparam int MAX_OUT  = 64;   // most outputs one point may produce
  localparam int SPAN_W   = 6;    // interpolated points per point, up to MAX_OUT-1
  localparam int M_W      = 7;    // interpolation divisor, up to MAX_OUT
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_POINTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd3;

  localparam logic [CNT_W-1:0] PTS_MAX  = 17'd65536;
  localparam logic [SMP_W-1:0] GAIN_RST = 32'h0001_0000;
  localparam logic [SMP_W-1:0] SMP_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] SMP_MIN  = {1'b1, {(SMP_W-1){1'b0}}};

  typedef struct packed {
    logic cfg_wr;      // register write
    logic in_load;     // input word taken
    logic mul;         // register scaling product
    logic rnd;         // round and saturate
    logic plan;        // expansion: work out the output span
    logic div_start;   // start shared divider
    logic div_ratio;   // divider operands: out_points / in_points
    logic int_load;    // take interpolation step from divider
    logic int_step;    // advance interpolation accumulator
    logic emit_int;    // load output with an interpolated point
    logic emit_cur;    // load output with the scaled point
    logic emit_err;    // load output with a ratio error word
    logic ratio_load;  // take per-point index step from divider
    logic advance;     // close out the input point
  } trm_cmd_t;

  typedef struct packed {
    logic drop_word;   // imaginary half of a complex pair
    logic mode_eq;
    logic mode_dec;
    logic hit_dec;     // decimation reaches the next output index
    logic exp_none;    // expansion: no output for this point
    logic exp_err;     // expansion: span above MAX_OUT-1
    logic exp_single;  // expansion: only the point itself
    logic need_ratio;  // expansion: first point, index step still unknown
    logic div_done;
    logic out_free;
    logic int_done;
  } trm_stat_t;

endpackage

FILE: rtl/core/trace_resample_minmax_interp_top.sv
// ----------------------------------------------------------------------------
// trace_resample_minmax_interp_top
// Display resampler: min/max decimation or linear interpolation of a trace.
// ----------------------------------------------------------------------------
// One input word is processed at a time. A word that maps one-to-one or is
// decimated goes through accept, multiply, round, emit, finish and advance;
// a decimated word that adds no output skips the emit. The imaginary word of a
// complex pair is only accepted. When expanding, a word that yields n points
// (n >= 2) waits on the shared bit-serial divider for the interpolation step;
// the first word of an expanded trace of more than one input word then uses
// that divider again to get the per-word output index step. A result word
// waiting in the output register does not block the next input word until
// the block has its next result ready. Register writes are taken only
// between words and restart the trace.
module trace_resample_minmax_interp_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trm_pkg::SMP_W-1:0]     in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trm_pkg::SMP_W-1:0]     out_value,
  output logic                          out_last,
  output logic                          out_ratio_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trm_pkg::SMP_W-1:0]     cfg_data
);
  import trm_pkg::*;

  trm_cmd_t  cmd;
  trm_stat_t stat;

  trm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  trm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_last        (out_last),
    .out_ratio_error (out_ratio_error)
  );

endmodule

FILE: rtl/core/trm_div.sv
// ----------------------------------------------------------------------------
// trm_div
// Restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
module trm_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] r_r;
  logic [DVS_W-1:0] d_r;

  logic [DVS_W:0]   shift;
  logic [DVS_W:0]   sub;
  logic             ge;

  assign shift = {r_r, q_r[DVD_W-1]};
  assign sub   = shift - {1'b0, d_r};
  assign ge    = shift >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[DVD_W-2:0], ge};
      r_r <= ge ? sub[DVS_W-1:0] : shift[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

FILE: rtl/core/trm_datapath.sv
// ----------------------------------------------------------------------------
// trm_datapath
// Config registers, trace state, scaling multiplier, interpolation
// accumulator, shared divider and the output register.
// ----------------------------------------------------------------------------
module trm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trm_pkg::trm_cmd_t                 cmd,
  output trm_pkg::trm_stat_t                stat,
  input  logic [trm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trm_pkg::SMP_W-1:0]         cfg_data,
  input  logic [trm_pkg::SMP_W-1:0]         in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [trm_pkg::SMP_W-1:0]         out_value,
  output logic                              out_last,
  output logic                              out_ratio_error
);
  import trm_pkg::*;

  function automatic logic [CNT_W-1:0] clamp_pts(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > PTS_MAX) r = PTS_MAX;
    return r;
  endfunction

  // config
  logic [CNT_W-1:0] in_pts_r, out_pts_r;
  logic             cplx_r;
  logic [SMP_W-1:0] gain_r;

  // trace state
  logic             phase_r;
  logic [SMP_W-1:0] min_r, max_r, prev_r;
  logic [CNT_W-1:0] in_cnt_r, out_cnt_r, t_r, trem_r;
  logic [CNT_W-1:0] q0_r, r0_r;
  logic             first_r, final_r;

  // per-point working registers
  logic [SMP_W-1:0]  x_r, cur_r, base_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r, last_r, dneg_r;
  logic [M_W-1:0]    m_r, rd_r, irem_r;
  logic [SPAN_W-1:0] nd_r, k_r;
  logic [SMP_W-1:0]  qd_r, iq_r;

  logic             out_valid_r, out_last_r, out_err_r;
  logic [SMP_W-1:0] out_value_r;

  logic mode_eq, mode_dec, mode_exp, drop_word, hit_dec;
  logic [CNT_W-1:0] n_out_m1, t_sel, span;
  logic exp_none, exp_err;
  logic [SMP_W-1:0] prev_sel;
  logic [SMP_W:0]   diff, dmag;
  logic [M_W-1:0]   m_plan;

  logic [SMP_W:0]    op, op_mag;
  logic [SMP_W-1:0]  gain_mag;
  logic [PROD_W-1:0] prod_full, rsum;
  logic              rhi;
  logic [SMP_W-1:0]  rlo, scaled;

  logic [M_W:0]     isum;
  logic             icarry;
  logic [M_W-1:0]   irem_nxt;
  logic [SMP_W-1:0] iq_nxt, interp_val;

  logic [CNT_W-1:0] step_q, step_r;
  logic [CNT_W:0]   tr_sum;
  logic             tr_wrap;
  logic [CNT_W-1:0] trem_nxt, t_nxt;

  logic             div_done;
  logic [SMP_W-1:0] div_dvd, div_quot;
  logic [CNT_W-1:0] div_dvs, div_rem;

  assign mode_eq   = in_pts_r == out_pts_r;
  assign mode_dec  = in_pts_r > out_pts_r;
  assign mode_exp  = in_pts_r < out_pts_r;
  assign drop_word = cplx_r & phase_r;
  assign n_out_m1  = out_pts_r - CNT_W'(1);
  assign hit_dec   = (out_cnt_r < out_pts_r) && (out_cnt_r == t_r);

  // expansion span: the final point always lands on the last output index
  assign t_sel    = final_r ? n_out_m1 : t_r;
  assign exp_none = t_sel < out_cnt_r;
  assign span     = t_sel - out_cnt_r;
  assign exp_err  = span > CNT_W'(MAX_OUT - 1);
  assign m_plan   = M_W'(span[SPAN_W-1:0]) + M_W'(1);
  assign prev_sel = first_r ? cur_r : prev_r;
  assign diff     = {cur_r[SMP_W-1], cur_r} - {prev_sel[SMP_W-1], prev_sel};
  assign dmag     = diff[SMP_W] ? (~diff + 1'b1) : diff;

  // scaling: sample goes in doubled so both paths round at bit 17
  assign op       = mode_dec ? ({min_r[SMP_W-1], min_r} + {max_r[SMP_W-1], max_r})
                             : {x_r, 1'b0};
  assign op_mag   = op[SMP_W] ? (~op + 1'b1) : op;
  assign gain_mag = gain_r[SMP_W-1] ? (~gain_r + 1'b1) : gain_r;
  assign prod_full = gain_mag * op_mag;

  assign rsum = prod_r + (PROD_W'(1) << (SCALE_SH - 1));
  assign rlo  = rsum[SCALE_SH +: SMP_W];
  assign rhi  = |rsum[PROD_W-1:SCALE_SH+SMP_W-1];
  always_comb begin
    if (neg_r) scaled = rhi ? SMP_MIN : (~rlo + 1'b1);
    else       scaled = rhi ? SMP_MAX : rlo;
  end

  // interpolation: q_k = (k*D + m/2) / m kept as running quotient/remainder
  assign isum       = {1'b0, irem_r} + {1'b0, rd_r};
  assign icarry     = isum >= {1'b0, m_r};
  assign irem_nxt   = icarry ? M_W'(isum - {1'b0, m_r}) : isum[M_W-1:0];
  assign iq_nxt     = iq_r + qd_r + SMP_W'(icarry);
  assign interp_val = dneg_r ? (base_r - iq_r) : (base_r + iq_r);

  // output index tracking: t = in_count*out_points/in_points
  assign step_q   = mode_dec ? '0 : q0_r;
  assign step_r   = mode_dec ? out_pts_r : r0_r;
  assign tr_sum   = {1'b0, trem_r} + {1'b0, step_r};
  assign tr_wrap  = tr_sum >= {1'b0, in_pts_r};
  assign trem_nxt = tr_wrap ? CNT_W'(tr_sum - {1'b0, in_pts_r}) : tr_sum[CNT_W-1:0];
  assign t_nxt    = t_r + step_q + CNT_W'(tr_wrap);

  assign div_dvd = cmd.div_ratio ? SMP_W'(out_pts_r) : dmag[SMP_W-1:0];
  assign div_dvs = cmd.div_ratio ? in_pts_r : CNT_W'(m_plan);

  trm_div #(
    .DVD_W (SMP_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pts_r  <= CNT_W'(1);
      out_pts_r <= CNT_W'(1);
      cplx_r    <= 1'b0;
      gain_r    <= GAIN_RST;
      phase_r   <= 1'b0;
      min_r     <= SMP_MAX;
      max_r     <= SMP_MIN;
      prev_r    <= '0;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      t_r       <= '0;
      trem_r    <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        case (cfg_index)
          REG_IN_POINTS:  in_pts_r  <= clamp_pts(cfg_data[CNT_W-1:0]);
          REG_OUT_POINTS: out_pts_r <= clamp_pts(cfg_data[CNT_W-1:0]);
          REG_WORD_STEP:  cplx_r    <= cfg_data[1];
          REG_GAIN:       gain_r    <= cfg_data;
          default: ;
        endcase
        min_r     <= SMP_MAX;
        max_r     <= SMP_MIN;
        prev_r    <= '0;
        in_cnt_r  <= '0;
        out_cnt_r <= '0;
        t_r       <= '0;
        trem_r    <= '0;
      end
      if (cmd.in_load) begin
        phase_r <= cplx_r & ~phase_r;
        if (!drop_word && mode_dec) begin
          if ($signed(in_sample) > $signed(max_r)) max_r <= in_sample;
          if ($signed(in_sample) < $signed(min_r)) min_r <= in_sample;
        end
      end
      if (cmd.rnd && mode_dec && hit_dec) begin
        out_cnt_r <= out_cnt_r + CNT_W'(1);
        min_r     <= SMP_MAX;
        max_r     <= SMP_MIN;
      end
      if (cmd.plan && !exp_none) out_cnt_r <= t_sel + CNT_W'(1);
      if (cmd.advance) begin
        if (final_r) begin
          min_r     <= SMP_MAX;
          max_r     <= SMP_MIN;
          prev_r    <= '0;
          in_cnt_r  <= '0;
          out_cnt_r <= '0;
          t_r       <= '0;
          trem_r    <= '0;
        end else begin
          prev_r   <= cur_r;
          in_cnt_r <= in_cnt_r + CNT_W'(1);
          t_r      <= t_nxt;
          trem_r   <= trem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_r     <= in_sample;
      first_r <= in_cnt_r == '0;
      final_r <= in_cnt_r == in_pts_r - CNT_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= prod_full;
      neg_r  <= gain_r[SMP_W-1] ^ op[SMP_W];
    end
    if (cmd.rnd) begin
      cur_r  <= scaled;
      last_r <= mode_eq ? final_r : (out_cnt_r == n_out_m1);
    end
    if (cmd.plan) begin
      last_r <= t_sel == n_out_m1;
      base_r <= prev_sel;
      dneg_r <= diff[SMP_W];
      m_r    <= m_plan;
      nd_r   <= span[SPAN_W-1:0];
    end
    if (cmd.int_load) begin
      qd_r   <= div_quot;
      rd_r   <= div_rem[M_W-1:0];
      iq_r   <= '0;
      irem_r <= m_r >> 1;
      k_r    <= '0;
    end
    if (cmd.int_step) begin
      iq_r   <= iq_nxt;
      irem_r <= irem_nxt;
      k_r    <= k_r + SPAN_W'(1);
    end
    if (cmd.ratio_load) begin
      q0_r <= div_quot[CNT_W-1:0];
      r0_r <= div_rem;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_int || cmd.emit_cur || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_int) begin
      out_value_r <= interp_val;
      out_last_r  <= 1'b0;
      out_err_r   <= 1'b0;
    end else if (cmd.emit_cur) begin
      out_value_r <= cur_r;
      out_last_r  <= last_r;
      out_err_r   <= 1'b0;
    end else if (cmd.emit_err) begin
      out_value_r <= '0;
      out_last_r  <= last_r;
      out_err_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_last        = out_last_r;
  assign out_ratio_error = out_err_r;

  always_comb begin
    stat            = '0;
    stat.drop_word  = drop_word;
    stat.mode_eq    = mode_eq;
    stat.mode_dec   = mode_dec;
    stat.hit_dec    = hit_dec;
    stat.exp_none   = exp_none;
    stat.exp_err    = exp_err;
    stat.exp_single = span == '0;
    stat.need_ratio = mode_exp & first_r & ~final_r;
    stat.div_done   = div_done;
    stat.out_free   = ~out_valid_r | out_ready;
    stat.int_done   = k_r == nd_r;
  end

endmodule

FILE: rtl/core/trm_ctrl.sv
// ----------------------------------------------------------------------------
// trm_ctrl
// Sequencer: walks one input word through scale, plan and interpolate (when
// expanding), emit and advance, one word at a time.
// ----------------------------------------------------------------------------
module trm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  trm_pkg::trm_stat_t stat,
  output trm_pkg::trm_cmd_t  cmd
);
  import trm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_RND  = 4'd2;
  localparam logic [3:0] ST_PLAN = 4'd3;
  localparam logic [3:0] ST_IDIV = 4'd4;
  localparam logic [3:0] ST_STEP = 4'd5;
  localparam logic [3:0] ST_EINT = 4'd6;
  localparam logic [3:0] ST_ECUR = 4'd7;
  localparam logic [3:0] ST_EERR = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;
  localparam logic [3:0] ST_QDIV = 4'd10;
  localparam logic [3:0] ST_ADV  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign cfg_ready = state_r == ST_IDLE;
  assign in_ready  = (state_r == ST_IDLE) & ~cfg_valid;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.cfg_wr = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.in_load = 1'b1;
          if (!stat.drop_word) state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd = 1'b1;
        if (stat.mode_eq) state_nxt = ST_ECUR;
        else if (stat.mode_dec) state_nxt = stat.hit_dec ? ST_ECUR : ST_FIN;
        else state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        cmd.plan = 1'b1;
        if (stat.exp_none) state_nxt = ST_FIN;
        else if (stat.exp_err) state_nxt = ST_EERR;
        else if (stat.exp_single) state_nxt = ST_ECUR;
        else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_IDIV;
        end
      end
      ST_IDIV: begin
        if (stat.div_done) begin
          cmd.int_load = 1'b1;
          state_nxt    = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.int_step = 1'b1;
        state_nxt    = ST_EINT;
      end
      ST_EINT: begin
        if (stat.out_free) begin
          cmd.emit_int = 1'b1;
          state_nxt    = stat.int_done ? ST_ECUR : ST_STEP;
        end
      end
      ST_ECUR: begin
        if (stat.out_free) begin
          cmd.emit_cur = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_EERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.need_ratio) begin
          cmd.div_start = 1'b1;
          cmd.div_ratio = 1'b1;
          state_nxt     = ST_QDIV;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_QDIV: begin
        cmd.div_ratio = 1'b1;
        if (stat.div_done) begin
          cmd.ratio_load = 1'b1;
          state_nxt      = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/core/trm_checker.sv
// ----------------------------------------------------------------------------
// trm_checker
// Port-level checks for the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module trm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [trm_pkg::SMP_W-1:0]     out_value,
  input logic                          out_last,
  input logic                          out_ratio_error,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last)
      && $stable(out_ratio_error))
    else $error("result word changed while stalled");

  // a register write and an input word never land together
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && cfg_valid && cfg_ready))
    else $error("register write and input word in one cycle");

  // a ratio error word carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ratio_error |-> out_value == '0)
    else $error("ratio error word with nonzero value");

  // new results are produced only while an input word is in work
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind trace_resample_minmax_interp_top trm_checker u_trm_checker (.*);

FILE: test/trace_resample_minmax_interp_top_tb.sv
// ============================================================================
// trace_resample_minmax_interp_top_tb
// Self-checking bench for the display trace resampler.
// A scoreboard class keeps its own copy of the registers and trace state,
// predicts every output word from the words taken in (pass-through,
// min/max decimation, linear expansion, ratio errors, complex pairs) and
// compares each output word field by field. A directed pass hits the
// extremes and corner cases, then randomized traces run with random input
// gaps and random result back-pressure.
// ============================================================================
module trace_resample_minmax_interp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trm_pkg::*;

  localparam longint SMP_HI        = 64'sd2147483647;
  localparam longint SMP_LO        = -64'sd2147483648;
  localparam int     SETTLE_CYCLES = 256;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             last;
    logic             ratio_error;
  } point_t;

  function automatic longint unsigned magn(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // round(g*x / 2^sh), ties away from zero, saturated to 32 bits
  function automatic longint scale_round(longint g, longint x, int sh);
    bit                neg;
    longint unsigned   m;
    longint unsigned   r;
    neg = (g < 0) != (x < 0);
    m   = magn(g) * magn(x);
    r   = (m + (64'd1 << (sh - 1))) >> sh;
    if (neg) return (r >= 64'h8000_0000) ? SMP_LO : -longint'(r);
    return (r > 64'h7FFF_FFFF) ? SMP_HI : longint'(r);
  endfunction

  function automatic longint unsigned clamp_count(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    return (v > PTS_MAX) ? longint'(PTS_MAX) : longint'(v);
  endfunction

  class resample_checker;
    logic [CNT_W-1:0] in_pts, out_pts;
    logic [1:0]       word_step;
    logic [SMP_W-1:0] gain;
    longint           run_min, run_max, prev_scaled;
    longint unsigned  in_count, out_count, ratio_acc;
    bit               word_phase;
    point_t           pending_points[$];
    int               fails, n_words, n_imag, n_predicted, n_checked, n_ratio_err;

    function new();
      in_pts     = 1;
      out_pts    = 1;
      word_step  = 1;
      gain       = GAIN_RST;
      word_phase = 0;
      restart_trace();
    endfunction

    function void restart_trace();
      run_min     = SMP_HI;
      run_max     = SMP_LO;
      in_count    = 0;
      out_count   = 0;
      ratio_acc   = 0;
      prev_scaled = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SMP_W-1:0] data);
      case (idx)
        REG_IN_POINTS:  in_pts    = data[CNT_W-1:0];
        REG_OUT_POINTS: out_pts   = data[CNT_W-1:0];
        REG_WORD_STEP:  word_step = data[1:0];
        REG_GAIN:       gain      = data;
        default: ;
      endcase
      restart_trace();
    endfunction

    function void push_point(longint v, bit last, bit err);
      point_t p;
      p.value       = v[SMP_W-1:0];
      p.last        = last;
      p.ratio_error = err;
      pending_points.push_back(p);
      n_predicted++;
    endfunction

    function int pending();
      return pending_points.size();
    endfunction

    // one accepted input word
    function void take_word(logic [SMP_W-1:0] word);
      longint unsigned n_in, n_out, t, cnt, nd, k, q;
      longint          g, x, cur, prev, diff, num;
      bit              final_pt;
      n_in  = clamp_count(in_pts);
      n_out = clamp_count(out_pts);
      g     = $signed(gain);
      x     = $signed(word);

      if (word_step >= 2) begin
        if (word_phase) begin
          word_phase = 0;
          n_imag++;
          return;
        end
        word_phase = 1;
      end else begin
        word_phase = 0;
      end
      n_words++;
      if (in_count >= n_in) restart_trace();
      final_pt = (in_count == n_in - 1);

      if (n_in == n_out) begin
        push_point(scale_round(g, x, 16), final_pt, 0);
      end else if (n_in > n_out) begin
        t = ratio_acc / n_in;
        if (x > run_max) run_max = x;
        if (x < run_min) run_min = x;
        if (out_count < n_out && out_count == t) begin
          push_point(scale_round(g, run_min + run_max, 17), out_count == n_out - 1, 0);
          out_count++;
          run_min = SMP_HI;
          run_max = SMP_LO;
        end
      end else begin
        cur  = scale_round(g, x, 16);
        prev = (in_count == 0) ? cur : prev_scaled;
        t    = final_pt ? n_out - 1 : ratio_acc / n_in;
        if (t >= out_count) begin
          cnt = t - out_count + 1;
          if (cnt > MAX_OUT) begin
            push_point(0, t == n_out - 1, 1);
          end else begin
            nd   = cnt - 1;
            diff = cur - prev;
            for (k = 1; k <= nd; k++) begin
              num = longint'(k) * diff;
              q   = (magn(num) + (nd + 1) / 2) / (nd + 1);
              push_point(prev + ((num < 0) ? -longint'(q) : longint'(q)), 0, 0);
            end
            push_point(cur, t == n_out - 1, 0);
          end
          out_count = t + 1;
        end
        prev_scaled = cur;
      end

      if (final_pt) begin
        restart_trace();
      end else begin
        in_count++;
        ratio_acc = (ratio_acc + n_out) & 64'h3_FFFF_FFFF;
      end
    endfunction

    function void check_point(logic [SMP_W-1:0] value, logic last, logic err);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("unexpected output word: value %0d last %b ratio_error %b",
               $signed(value), last, err);
        fails++;
        return;
      end
      want = pending_points.pop_front();
      n_checked++;
      if (want.ratio_error) n_ratio_err++;
      if (value !== want.value) begin
        $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
        fails++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        fails++;
      end
      if (err !== want.ratio_error) begin
        $error("ratio_error: expected %b, got %b", want.ratio_error, err);
        fails++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SMP_W-1:0]     in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SMP_W-1:0]     out_value;
  logic                 out_last;
  logic                 out_ratio_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SMP_W-1:0]     cfg_data = '0;

  resample_checker sb = new();
  bit              calm;
  int              n_settings;

  trace_resample_minmax_interp_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_last        (out_last),
    .out_ratio_error (out_ratio_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short stalls, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // result side: random back-pressure with steady stretches
  initial begin
    int hold;
    int span;
    bit steady;
    hold = 0;
    span = 0;
    steady = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_point(out_value, out_last, out_ratio_error);
      if (span == 0) begin
        span   = $urandom_range(50, 400);
        steady = ($urandom_range(0, 3) == 0);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
      end else begin
        hold = gap_len() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [SMP_W-1:0] s);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.take_word(s);
  endtask

  // drain all expected words, then let a word with no output finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SMP_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_cfg(input logic [SMP_W-1:0] n_in, input logic [SMP_W-1:0] n_out,
                         input logic [SMP_W-1:0] wstep, input logic [SMP_W-1:0] g);
    settle();
    write_reg(REG_IN_POINTS, n_in, 1);
    write_reg(REG_OUT_POINTS, n_out, 1);
    write_reg(REG_WORD_STEP, wstep, 1);
    write_reg(REG_GAIN, g, 0);
    n_settings++;
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return SMP_MAX;
        1:       return SMP_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 5) return SMP_W'($urandom_range(0, 2000)) - 32'd1000;
    return $urandom;
  endfunction

  function automatic logic [SMP_W-1:0] rand_gain();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return GAIN_RST;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0:       return SMP_MAX;
        1:       return SMP_MIN;
        2:       return '0;
        default: return 32'hFFFF_0000;
      endcase
    end
    if (r == 2) return $urandom;
    return SMP_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;   // within +/-2.0
  endfunction

  // count register value, with 0 standing for 1 and junk above bit 16 at times
  function automatic logic [SMP_W-1:0] count_reg(int n);
    logic [SMP_W-1:0] v;
    v = (n == 1 && $urandom_range(0, 1) == 1) ? '0 : SMP_W'(n);
    if ($urandom_range(0, 3) == 0) v[SMP_W-1:CNT_W] = (SMP_W-CNT_W)'($urandom);
    return v;
  endfunction

  initial begin
    int start_words, start_pts, mode, n_in, n_out, wstep, n_send, r;
    calm = 0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-to-one, unit gain
    send_word(SMP_MAX);
    send_word(SMP_MIN);
    send_word('0);
    send_word('1);

    // counts of 0 act as 1, step 3 as complex pairs, max gain saturates
    set_cfg(0, 0, 3, SMP_MAX);
    send_word(SMP_MAX);
    send_word(32'h1234_5678);
    send_word(SMP_MIN);
    send_word(32'd1);
    send_word(32'd1);
    send_word(32'hDEAD_BEEF);
    set_cfg(1, 1, 1, SMP_MIN);
    send_word(SMP_MIN);
    send_word(SMP_MAX);
    send_word(32'd1);

    // decimation, gain 0.5 gives half-way ties
    set_cfg(5, 2, 1, 32'h0000_8000);
    send_word(32'd1);
    send_word(-32'sd3);
    send_word(32'd7);
    send_word(-32'sd1);
    send_word(32'd2);

    // expansion with negative gain -1.5
    set_cfg(3, 7, 1, 32'hFFFE_8000);
    send_word(32'd100);
    send_word(-32'sd50);
    send_word(32'd7);

    // single point spread over the most outputs allowed
    set_cfg(1, 64, 2, GAIN_RST);
    send_word(32'd12345);
    send_word(32'h5555_AAAA);

    // excess expansion, with and without a preceding point
    set_cfg(2, 131071, 1, GAIN_RST);
    send_word(32'd10);
    send_word(32'd20);
    set_cfg(1, 65536, 1, GAIN_RST);
    send_word(-32'sd77);

    // largest counts, upper register bits ignored
    set_cfg(65536, 1, 1, GAIN_RST);
    send_word(32'd500);
    send_word(-32'sd500);
    set_cfg(32'hFFFF_FFFF, 65536, 32'hFFFF_FFFE, GAIN_RST);
    send_word(32'd9);
    // a write between the halves of a pair keeps the pair phase
    settle();
    write_reg(REG_GAIN, 32'h0003_0000, 0);
    send_word(32'h7777_0000);
    send_word(32'd3);

    start_words = sb.n_words + sb.n_imag;
    start_pts   = sb.n_predicted;
    while (sb.n_words + sb.n_imag - start_words < 70 || sb.n_predicted - start_pts < 48) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        n_in  = $urandom_range(1, 6);
        n_out = n_in;
      end else if (mode < 5) begin
        n_in  = $urandom_range(2, 12);
        n_out = $urandom_range(1, n_in - 1);
      end else if (mode < 9) begin
        n_in  = $urandom_range(1, 4);
        n_out = n_in + $urandom_range(1, 20 * n_in);
      end else begin
        n_in  = $urandom_range(1, 3);
        n_out = ($urandom_range(0, 1) == 1) ? 65536 : n_in * $urandom_range(65, 90);
      end
      wstep = $urandom_range(0, 3);
      set_cfg(count_reg(n_in), count_reg(n_out), SMP_W'(wstep), rand_gain());
      calm = ($urandom_range(0, 4) == 0);

      // mostly whole traces; some cut short, some running into the next
      r      = $urandom_range(0, 9);
      n_send = n_in;
      if (r == 0) n_send = $urandom_range(1, n_in);
      else if (r == 1) n_send = n_in + $urandom_range(1, 3);
      if (wstep >= 2) n_send = 2 * n_send - ((r == 0) ? $urandom_range(0, 1) : 0);
      repeat (n_send) send_word(rand_sample());
      calm = 0;
    end

    settle();
    $display("Covered %0d data words and %0d skipped imaginary words over %0d settings,",
             sb.n_words, sb.n_imag, n_settings);
    $display("with %0d output words checked, %0d of them ratio errors.",
             sb.n_checked, sb.n_ratio_err);
    if (sb.fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
